/* rtl/blagr_pkg.sv */
// ----------------------------------------------------------------------------
// blagr_pkg
// Shared types and constants for the bounded list core: command and status
// codes, field widths and the command word broadcast to the list cells.
// ----------------------------------------------------------------------------
package blagr_pkg;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 4;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;
  localparam int OUT_DW = 32;

  // count and capacity never exceed what a 5-bit field holds
  localparam int CNT_MAX = (1 << CNT_W) - 1;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  // register indexes
  localparam int REG_CAPACITY = 0;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD     = 2'd1,
    STAT_MISSING = 2'd2
  } status_t;

  // command word seen by every cell
  typedef struct packed {
    logic append;   // store write data at the tail slot
    logic compare;  // capture the match flag against write data
    logic remove;   // cells at or above the hit slot take their neighbor's word
  } cell_cmd_t;

endpackage

/* rtl/bounded_list_append_get_remove_core.sv */
// ----------------------------------------------------------------------------
// bounded_list_append_get_remove_core
// Ordered list of signed words held in a row of slot cells.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall (command, value, index); each request
// gives exactly one result on out_valid/out_stall (status, read_value, count).
// Append and read finish in the accept cycle: the result is registered and
// shows in the cycle after accept, so these run at one request per cycle
// while the output is not stalled. For remove, every cell compares against
// the value in the accept cycle; in S_REMOVE, once the output is free, the
// core picks the last match and shifts the upper cells down by one. Input
// stays stalled until the shift is done, so no request overlaps a remove.
// Read is served from the first 16 slots. The single output register
// decouples the sides: a new request is taken while a result is waiting as
// long as the receiver is not stalling it. While out_stall holds, the result
// stays put and in_stall goes high. Capacity is written over the APB port
// (byte address 0) only while idle, which the user, not the block, enforces.
// Reset (rst_n low, synchronous) empties the list and sets capacity to 16;
// slot contents are not cleared, only slots below the count are visible.
// ----------------------------------------------------------------------------
module bounded_list_append_get_remove_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [blagr_pkg::CMD_W-1:0]       in_command,
  input  logic signed [31:0]                in_value,
  input  logic [blagr_pkg::IDX_W-1:0]       in_index,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [blagr_pkg::STAT_W-1:0]      out_status,
  output logic signed [blagr_pkg::OUT_DW-1:0] out_read_value,
  output logic [blagr_pkg::CNT_W-1:0]       out_count,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import blagr_pkg::*;

  localparam int               RD_N      = 1 << IDX_W;
  localparam int               DEPTH_CAP = (DEPTH > CNT_MAX) ? CNT_MAX : DEPTH;
  localparam logic [CNT_W-1:0] DEPTH_LIM = CNT_W'(DEPTH_CAP);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_REMOVE = 2'b10
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         cap_r, cap_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]        out_status_r, out_status_nxt;
  logic [OUT_DW-1:0]        out_rd_r, out_rd_nxt;
  logic [CNT_W-1:0]         out_cnt_r, out_cnt_nxt;

  logic                     accept;
  logic                     out_free;
  logic                     room;
  logic                     rd_ok;
  logic                     found;
  logic                     reg_sel;
  logic [DATA_WIDTH-1:0]    wdata;
  logic [DATA_WIDTH-1:0]    rd_sel;
  logic [DEPTH-1:0]         match_vec;
  logic [DEPTH-1:0]         later_hit;
  logic [DATA_WIDTH-1:0]    cell_data [DEPTH];
  logic [DATA_WIDTH-1:0]    rd_tbl    [RD_N];
  cell_cmd_t                cmd;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign wdata = DATA_WIDTH'($unsigned(in_value));
  assign room  = (cnt_r < cap_r) && (cnt_r < DEPTH_LIM);
  assign rd_ok = {1'b0, in_index} < cnt_r;
  assign found = |match_vec;

  assign cmd.append  = accept && (in_command == CMD_APPEND) && room;
  assign cmd.compare = accept && (in_command == CMD_REMOVE);
  assign cmd.remove  = (state_r == S_REMOVE) && out_free && found;

  // ---- slot cells ----
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] nbr;

    if (i == DEPTH - 1) begin : g_top
      assign nbr = cell_data[i];
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end

    // a match above this slot means the removed word sits higher up
    assign later_hit[i] = |(match_vec >> (i + 1));

    blagr_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .SLOT       (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .cnt       (cnt_r),
      .wdata     (wdata),
      .nbr_data  (nbr),
      .later_hit (later_hit[i]),
      .data_o    (cell_data[i]),
      .match_o   (match_vec[i])
    );
  end

  // read port covers the slots an index can reach
  for (genvar j = 0; j < RD_N; j++) begin : g_rd
    if (j < DEPTH) begin : g_hit
      assign rd_tbl[j] = cell_data[j];
    end else begin : g_none
      assign rd_tbl[j] = '0;
    end
  end

  assign rd_sel = rd_tbl[in_index];

  // ---- configuration ----
  assign reg_sel = (paddr[2] == 1'(REG_CAPACITY));
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? 32'(cap_r) : '0;

  always_comb begin
    cap_nxt = cap_r;
    if (psel && penable && pwrite && reg_sel) begin
      cap_nxt = pwdata[CNT_W-1:0];
    end
  end

  // ---- request sequencing ----
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_rd_nxt     = out_rd_r;
    out_cnt_nxt    = out_cnt_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_rd_nxt = '0;
          unique case (in_command)
            CMD_APPEND: begin
              out_valid_nxt = 1'b1;
              if (room) begin
                cnt_nxt        = CNT_W'(cnt_r + 1'b1);
                out_status_nxt = STAT_OK;
              end else begin
                out_status_nxt = STAT_BAD;
              end
              out_cnt_nxt = room ? CNT_W'(cnt_r + 1'b1) : cnt_r;
            end
            CMD_READ: begin
              out_valid_nxt = 1'b1;
              out_cnt_nxt   = cnt_r;
              if (rd_ok) begin
                out_status_nxt = STAT_OK;
                out_rd_nxt     = OUT_DW'(signed'(rd_sel));
              end else begin
                out_status_nxt = STAT_BAD;
              end
            end
            CMD_REMOVE: begin
              state_nxt = S_REMOVE;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_BAD;
              out_cnt_nxt    = cnt_r;
            end
          endcase
        end
      end
      S_REMOVE: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_rd_nxt    = '0;
          if (found) begin
            cnt_nxt        = CNT_W'(cnt_r - 1'b1);
            out_status_nxt = STAT_OK;
            out_cnt_nxt    = CNT_W'(cnt_r - 1'b1);
          end else begin
            out_status_nxt = STAT_MISSING;
            out_cnt_nxt    = cnt_r;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_rd_r     <= out_rd_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = signed'(out_rd_r);
  assign out_count      = out_cnt_r;

endmodule

/* rtl/blagr_cell.sv */
// ----------------------------------------------------------------------------
// blagr_cell
// One list slot: holds a word, writes it on append at the tail, flags a
// match on compare and takes the upper neighbor's word on remove.
// ----------------------------------------------------------------------------
module blagr_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int SLOT       = 0
) (
  input  logic                     clk,
  input  blagr_pkg::cell_cmd_t     cmd,
  input  logic [blagr_pkg::CNT_W-1:0] cnt,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic [DATA_WIDTH-1:0]    nbr_data,
  input  logic                     later_hit,
  output logic [DATA_WIDTH-1:0]    data_o,
  output logic                     match_o
);
  import blagr_pkg::*;

  // slots past the largest possible count are never filled
  localparam bit               REACH = (SLOT < CNT_MAX);
  localparam logic [CNT_W-1:0] POS   = REACH ? CNT_W'(SLOT) : '0;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  match_r;
  logic                  match_nxt;
  logic                  at_tail;
  logic                  in_use;

  assign at_tail = REACH && (cnt == POS);
  assign in_use  = REACH && (POS < cnt);

  always_comb begin
    data_nxt  = data_r;
    match_nxt = match_r;
    if (cmd.append && at_tail) begin
      data_nxt = wdata;
    end
    if (cmd.remove && !later_hit) begin
      data_nxt = nbr_data;
    end
    if (cmd.compare) begin
      match_nxt = in_use && (data_r == wdata);
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

  assign data_o  = data_r;
  assign match_o = match_r;

endmodule
